### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the slot pool.
// No dependencies; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define SPL_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define SPL_ASSERT(lbl, clk, rst, prop)
`define SPL_NEVER(lbl, clk, rst, expr)
`endif
`endif

### hw/rtl/spl_pkg.sv
// Shared types and constants of the slot pool with lifetime expiry.
// No dependencies.
package spl_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int TIMER_W  = 16;
   localparam int CSR_ADDR_W = 3;

   localparam logic [TIMER_W-1:0] LIFETIME_RESET = 16'd1000;
   localparam logic [TIMER_W-1:0] TIMER_MAX      = 16'hFFFF;

   localparam logic REG_LIFETIME = 1'b0;

   localparam logic [1:0] OP_TICK        = 2'd0;
   localparam logic [1:0] OP_ALLOC       = 2'd1;
   localparam logic [1:0] OP_RELEASE     = 2'd2;
   localparam logic [1:0] OP_RELEASE_ALL = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_ALLOC,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] elapsed;
      logic [5:0] slot;
   } req_type;

   typedef struct packed {
      logic       granted;
      logic [5:0] granted_slot;
      logic [6:0] active_count;
   } rsp_type;

endpackage

### hw/rtl/spl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

### hw/rtl/slot_pool_with_lifetime_expiry_unit.sv
// Top level of the slot pool with lifetime expiry: command port, CSR port,
// active-bit row and sweep control. Uses spl_pkg, spl_ram, assert_macros.svh.
//
// One command is taken while busy is low; its result appears on rsp_data for
// exactly one cycle with rsp_strobe high and cannot be held off. For a tick,
// the age timers sit in one RAM with one read and one write port; the sweep
// reads one timer per cycle from slot 0 up to the last slot, writes each
// updated value back in the following cycle, drains once the last write is
// done, then presents the result. An allocate scans the active bits one slot
// per cycle from slot 0 and stops at the lowest free slot, or after the last
// slot when the pool is full. Release and release-all go straight to the
// result. busy stays high while the result beat is out, so the next command
// is accepted in the cycle after the result beat at the earliest.
// No clearing pass is needed after reset.
`include "assert_macros.svh"

module slot_pool_with_lifetime_expiry_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  spl_pkg::req_type                 req_data,
   output logic                             rsp_strobe,
   output spl_pkg::rsp_type                 rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [spl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   localparam int IDX_W   = spl_pkg::IDX_W;
   localparam int CNT_W   = spl_pkg::CNT_W;
   localparam int TIMER_W = spl_pkg::TIMER_W;

   spl_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [spl_pkg::CAPACITY-1:0] active_ff, active_in;
   logic [CNT_W-1:0]          total_ff, total_in;
   logic [TIMER_W-1:0]        lifetime_ff, lifetime_in;
   logic                      wb_vld_ff, wb_vld_in;
   logic [IDX_W-1:0]          wb_addr_ff, wb_addr_in;
   logic [7:0]                elapsed_ff, elapsed_in;
   logic                      granted_ff, granted_in;
   logic [IDX_W-1:0]          gslot_ff, gslot_in;

   logic                      rd_en, wr_en;
   logic [IDX_W-1:0]          rd_addr, wr_addr;
   logic [TIMER_W-1:0]        rd_data, wr_data;
   logic [TIMER_W:0]          sum;
   logic [TIMER_W-1:0]        sat;
   logic [IDX_W-1:0]          scan_idx;
   logic [IDX_W-1:0]          rel_idx;
   logic                      rel_in_range;
   logic                      accept;
   logic                      csr_wr;

   spl_ram #(
      .WIDTH(TIMER_W),
      .DEPTH(spl_pkg::CAPACITY)
   ) u_timer_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept       = start && (state_ff == spl_pkg::ST_IDLE);
   assign scan_idx     = cnt_ff[IDX_W-1:0];
   assign rel_idx      = IDX_W'(req_data.slot);
   assign rel_in_range = 32'(req_data.slot) < spl_pkg::CAPACITY;
   assign sum          = {1'b0, rd_data} + {{(TIMER_W - 7){1'b0}}, elapsed_ff};
   assign sat          = sum[TIMER_W] ? spl_pkg::TIMER_MAX : sum[TIMER_W-1:0];

   // CSR port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   always_comb begin
      lifetime_in = lifetime_ff;
      if (csr_wr && (csr_paddr[2] == spl_pkg::REG_LIFETIME)) begin
         lifetime_in = csr_pwdata[TIMER_W-1:0];
      end
      csr_prdata = 32'd0;
      if (csr_paddr[2] == spl_pkg::REG_LIFETIME) begin
         csr_prdata = {{(32 - TIMER_W){1'b0}}, lifetime_ff};
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      active_in  = active_ff;
      total_in   = total_ff;
      wb_vld_in  = 1'b0;
      wb_addr_in = wb_addr_ff;
      elapsed_in = elapsed_ff;
      granted_in = granted_ff;
      gslot_in   = gslot_ff;
      rd_en      = 1'b0;
      rd_addr    = scan_idx;
      wr_en      = 1'b0;
      wr_addr    = wb_addr_ff;
      wr_data    = sat;

      case (state_ff)
         spl_pkg::ST_IDLE: begin
            if (accept) begin
               elapsed_in = req_data.elapsed;
               cnt_in     = '0;
               granted_in = 1'b0;
               gslot_in   = '0;
               case (req_data.opcode)
                  spl_pkg::OP_TICK: begin
                     state_in = spl_pkg::ST_TICK;
                  end
                  spl_pkg::OP_ALLOC: begin
                     state_in = spl_pkg::ST_ALLOC;
                  end
                  spl_pkg::OP_RELEASE: begin
                     if (rel_in_range && active_ff[rel_idx]) begin
                        active_in[rel_idx] = 1'b0;
                        total_in           = total_ff - CNT_W'(1);
                     end
                     state_in = spl_pkg::ST_RESP;
                  end
                  spl_pkg::OP_RELEASE_ALL: begin
                     active_in = '0;
                     total_in  = '0;
                     state_in  = spl_pkg::ST_RESP;
                  end
                  default: begin
                     state_in = spl_pkg::ST_RESP;
                  end
               endcase
            end
         end
         spl_pkg::ST_TICK: begin
            // issue the next read while the previous timer is written back
            if (cnt_ff != CNT_W'(spl_pkg::CAPACITY)) begin
               rd_en      = 1'b1;
               cnt_in     = cnt_ff + CNT_W'(1);
               wb_vld_in  = 1'b1;
               wb_addr_in = scan_idx;
            end
            if (wb_vld_ff) begin
               wr_en = 1'b1;
               if (active_ff[wb_addr_ff] && (sat > lifetime_ff)) begin
                  active_in[wb_addr_ff] = 1'b0;
                  total_in              = total_ff - CNT_W'(1);
               end
            end
            if ((cnt_ff == CNT_W'(spl_pkg::CAPACITY)) && !wb_vld_ff) begin
               state_in = spl_pkg::ST_RESP;
            end
         end
         spl_pkg::ST_ALLOC: begin
            if (!active_ff[scan_idx]) begin
               active_in[scan_idx] = 1'b1;
               total_in            = total_ff + CNT_W'(1);
               wr_en               = 1'b1;
               wr_addr             = scan_idx;
               wr_data             = '0;
               granted_in          = 1'b1;
               gslot_in            = scan_idx;
               state_in            = spl_pkg::ST_RESP;
            end else if (cnt_ff == CNT_W'(spl_pkg::CAPACITY - 1)) begin
               state_in = spl_pkg::ST_RESP;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         spl_pkg::ST_RESP: begin
            state_in = spl_pkg::ST_IDLE;
         end
         default: begin
            state_in = spl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= spl_pkg::ST_IDLE;
         cnt_ff      <= '0;
         active_ff   <= '0;
         total_ff    <= '0;
         lifetime_ff <= spl_pkg::LIFETIME_RESET;
         wb_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         active_ff   <= active_in;
         total_ff    <= total_in;
         lifetime_ff <= lifetime_in;
         wb_vld_ff   <= wb_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff <= wb_addr_in;
      elapsed_ff <= elapsed_in;
      granted_ff <= granted_in;
      gslot_ff   <= gslot_in;
   end

   assign busy                  = (state_ff != spl_pkg::ST_IDLE);
   assign rsp_strobe            = (state_ff == spl_pkg::ST_RESP);
   assign rsp_data.granted      = granted_ff;
   assign rsp_data.granted_slot = 6'(gslot_ff);
   assign rsp_data.active_count = 7'(total_ff);

   `SPL_ASSERT(a_strobe_single, clock, reset, rsp_strobe |=> !rsp_strobe)
   `SPL_ASSERT(a_count_matches, clock, reset, 32'(total_ff) == $countones(active_ff))
   `SPL_ASSERT(a_grant_active, clock, reset, (rsp_strobe && granted_ff) |-> active_ff[gslot_ff])
   `SPL_NEVER(a_wb_outside_tick, clock, reset, wb_vld_ff && (state_ff != spl_pkg::ST_TICK))

endmodule
